// ===== hdl/vector_angle_degrees_macros.svh =====
// Assertion macros used by the checker of the vector angle block.
`ifndef VECTOR_ANGLE_DEGREES_MACROS_SVH
`define VECTOR_ANGLE_DEGREES_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VAD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VAD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/vad_pkg.sv =====
// Shared constants, types and the arctangent table of the vector angle block.
package vad_pkg;

	// Width the dot and cross magnitudes are scaled to before rotation.
	localparam int WORK_BITS = 30;
	// Fraction bits of the accumulated angle in degrees.
	localparam int ANG_FRAC = 24;
	localparam int TAB_LEN = 32;
	// Rotation datapath: the gain of the rotations needs two more bits plus sign.
	localparam int CW = WORK_BITS + 3;
	// Angle accumulator, signed, holds -100 to 280 degrees.
	localparam int ZW = ANG_FRAC + 10;

	localparam logic [ZW-1:0] DEG180 = ZW'(180) << ANG_FRAC;
	localparam logic [ZW-1:0] DEG360 = ZW'(360) << ANG_FRAC;

	// How the final angle is formed: from the rotations or as a fixed value.
	typedef enum logic [2:0] {
		KIND_CORDIC,
		KIND_0,
		KIND_90,
		KIND_180,
		KIND_270
	} kind_t;

	typedef struct packed {
		logic  zero;
		logic  xneg;
		logic  yneg;
		kind_t kind;
	} tag_t;

	// atan(2^-idx) in degrees with ANG_FRAC fraction bits.
	function automatic logic [ZW-1:0] atan_deg(input int idx);
		logic [ZW-1:0] val;
		case (idx)
			0:  val = ZW'(754974720);
			1:  val = ZW'(445687602);
			2:  val = ZW'(235489088);
			3:  val = ZW'(119537938);
			4:  val = ZW'(60000934);
			5:  val = ZW'(30029717);
			6:  val = ZW'(15018523);
			7:  val = ZW'(7509720);
			8:  val = ZW'(3754917);
			9:  val = ZW'(1877466);
			10: val = ZW'(938734);
			11: val = ZW'(469367);
			12: val = ZW'(234684);
			13: val = ZW'(117342);
			14: val = ZW'(58671);
			15: val = ZW'(29335);
			16: val = ZW'(14668);
			17: val = ZW'(7334);
			18: val = ZW'(3667);
			19: val = ZW'(1833);
			20: val = ZW'(917);
			21: val = ZW'(458);
			22: val = ZW'(229);
			23: val = ZW'(115);
			24: val = ZW'(57);
			25: val = ZW'(29);
			26: val = ZW'(14);
			27: val = ZW'(7);
			28: val = ZW'(4);
			29: val = ZW'(2);
			30: val = ZW'(1);
			default: val = '0;
		endcase
		return val;
	endfunction

endpackage

// ===== hdl/vector_angle_degrees.sv =====
// Top level of the vector angle block: front end, shifter and rotation chains, output buffer.
//
// The block takes a pair of 2D integer vectors on the slave stream and returns the angle
// from the first to the second in degrees, 0 up to below 360, with FRAC_BITS fraction
// bits, on the master stream. One request in gives exactly one request out, in order.
// A request enters at a rising edge where s_axis_tvalid and s_axis_tready are both high,
// and while the receiver keeps up a new one may follow in every cycle: the sustained
// rate is one pair per clock. From acceptance to m_axis_tvalid a request passes the
// three front-end stages (multipliers, sums, magnitudes), the normalising shifter, the
// load stage, one rotation cell per CORDIC iteration, the two rounding stages and the
// output register.
// When either vector is zero the result is 90 degrees with the zero flag in tuser set.
// The whole pipeline advances together. When the receiver stalls, the result that is
// presented holds steady and the next one to leave the pipeline is parked in a skid
// register; s_axis_tready drops as soon as that register is filled and never depends
// combinationally on m_axis_tready.
// Reset clears every valid bit, those of the output and skid registers included; the
// data registers are not reset, and there is no other state.
module vector_angle_degrees import vad_pkg::*; #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS = 8,
	parameter int CORDIC_STAGES = 16
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          s_axis_tvalid,
	output logic                                          s_axis_tready,
	// first_x, first_y, second_x, second_y, zero padding
	input  logic [((4 * COORD_BITS + 7) / 8) * 8 - 1:0]   s_axis_tdata,
	output logic                                          m_axis_tvalid,
	input  logic                                          m_axis_tready,
	// angle_q8, zero padding
	output logic [((FRAC_BITS + 9 + 7) / 8) * 8 - 1:0]    m_axis_tdata,
	// zero_input
	output logic [0:0]                                    m_axis_tuser
);

	localparam int AW = FRAC_BITS + 9;
	localparam int OUT_W = ((FRAC_BITS + 9 + 7) / 8) * 8;
	localparam int NORM_BITS = (2 * COORD_BITS > WORK_BITS) ? 2 * COORD_BITS : WORK_BITS;
	localparam int NSH = $clog2(NORM_BITS);

	// Whole pipeline moves while the skid register is free.
	logic en;

	logic signed [COORD_BITS-1:0] first_x, first_y, second_x, second_y;

	// Normalising shifter chain.
	logic                 nv   [NSH+1];
	tag_t                 ntag [NSH+1];
	logic [NORM_BITS-1:0] nx   [NSH+1];
	logic [NORM_BITS-1:0] ny   [NSH+1];

	// Load stage between the shifter and the rotations.
	logic                 ld_valid_s1;
	tag_t                 ld_tag_s1;
	logic signed [CW-1:0] ld_x_s1, ld_y_s1, ym_ext;
	logic signed [ZW-1:0] ld_z_s1;
	logic [WORK_BITS-1:0] xm_top, ym_top;

	// Rotation chain.
	logic                 cv   [CORDIC_STAGES+1];
	tag_t                 ctag [CORDIC_STAGES+1];
	logic signed [CW-1:0] cx   [CORDIC_STAGES+1];
	logic signed [CW-1:0] cy   [CORDIC_STAGES+1];
	logic signed [ZW-1:0] cz   [CORDIC_STAGES+1];

	// Rounded result and the output buffer.
	logic          rd_valid, rd_zero;
	logic [AW-1:0] rd_angle;
	logic          out_valid_q, out_zero_q, skid_valid_q, skid_zero_q;
	logic [AW-1:0] out_angle_q, skid_angle_q;

	assign en            = !skid_valid_q;
	assign s_axis_tready = en;

	assign first_x  = s_axis_tdata[COORD_BITS-1:0];
	assign first_y  = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
	assign second_x = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
	assign second_y = s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS];

	vad_front #(
		.COORD_BITS(COORD_BITS),
		.NORM_BITS (NORM_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_axis_tvalid),
		.first_x  (first_x),
		.first_y  (first_y),
		.second_x (second_x),
		.second_y (second_y),
		.out_valid(nv[0]),
		.out_tag  (ntag[0]),
		.dot_mag  (nx[0]),
		.ncr_mag  (ny[0])
	);

	// Largest shift first: together the cells move the leading one of the larger
	// magnitude to the top bit, which is how both are brought to WORK_BITS bits.
	for (genvar k = 0; k < NSH; k++) begin : g_norm
		vad_norm_cell #(
			.NORM_BITS(NORM_BITS),
			.SHIFT    (1 << (NSH - 1 - k))
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (nv[k]),
			.in_tag   (ntag[k]),
			.in_x     (nx[k]),
			.in_y     (ny[k]),
			.out_valid(nv[k+1]),
			.out_tag  (ntag[k+1]),
			.out_x    (nx[k+1]),
			.out_y    (ny[k+1])
		);
	end

	// The top WORK_BITS bits are the scaled magnitudes. The negated cross product takes
	// its sign here; a negative dot product is turned half a turn by flipping y and
	// starting the angle at 180 degrees, which keeps x positive for the rotations.
	assign xm_top = nx[NSH][NORM_BITS-1 -: WORK_BITS];
	assign ym_top = ny[NSH][NORM_BITS-1 -: WORK_BITS];
	assign ym_ext = CW'(ym_top);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_valid_s1 <= 1'b0;
		end else if (en) begin
			ld_valid_s1 <= nv[NSH];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ld_tag_s1 <= ntag[NSH];
			ld_x_s1   <= CW'(xm_top);
			ld_y_s1   <= (ntag[NSH].xneg ^ ntag[NSH].yneg) ? -ym_ext : ym_ext;
			ld_z_s1   <= ntag[NSH].xneg ? DEG180 : '0;
		end
	end

	assign cv[0]   = ld_valid_s1;
	assign ctag[0] = ld_tag_s1;
	assign cx[0]   = ld_x_s1;
	assign cy[0]   = ld_y_s1;
	assign cz[0]   = ld_z_s1;

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
		vad_cordic_cell #(
			.STAGE(g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (cv[g]),
			.in_tag   (ctag[g]),
			.in_x     (cx[g]),
			.in_y     (cy[g]),
			.in_z     (cz[g]),
			.out_valid(cv[g+1]),
			.out_tag  (ctag[g+1]),
			.out_x    (cx[g+1]),
			.out_y    (cy[g+1]),
			.out_z    (cz[g+1])
		);
	end

	vad_round #(
		.FRAC_BITS(FRAC_BITS)
	) u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (cv[CORDIC_STAGES]),
		.in_tag   (ctag[CORDIC_STAGES]),
		.in_z     (cz[CORDIC_STAGES]),
		.out_valid(rd_valid),
		.out_zero (rd_zero),
		.out_angle(rd_angle)
	);

	// Output register with a skid register behind it. A result leaving the pipeline
	// goes straight to the output when that is free or being taken, otherwise into
	// the skid register, which then halts the pipeline until the output drains.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (en && rd_valid) begin
				if (!out_valid_q || m_axis_tready) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q  <= skid_valid_q;
				skid_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && rd_valid) begin
			if (!out_valid_q || m_axis_tready) begin
				out_angle_q <= rd_angle;
				out_zero_q  <= rd_zero;
			end else begin
				skid_angle_q <= rd_angle;
				skid_zero_q  <= rd_zero;
			end
		end else if (out_valid_q && m_axis_tready && skid_valid_q) begin
			out_angle_q <= skid_angle_q;
			out_zero_q  <= skid_zero_q;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = OUT_W'(out_angle_q);
	assign m_axis_tuser[0] = out_zero_q;

endmodule

// ===== hdl/vad_front.sv =====
// Front end: products, dot and negated cross sums, sign and magnitude, special cases.
module vad_front import vad_pkg::*; #(
	parameter int COORD_BITS = 16,
	parameter int NORM_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic signed [COORD_BITS-1:0] first_x,
	input  logic signed [COORD_BITS-1:0] first_y,
	input  logic signed [COORD_BITS-1:0] second_x,
	input  logic signed [COORD_BITS-1:0] second_y,
	output logic                         out_valid,
	output tag_t                         out_tag,
	output logic [NORM_BITS-1:0]         dot_mag,
	output logic [NORM_BITS-1:0]         ncr_mag
);

	localparam int PW = 2 * COORD_BITS;

	logic                 valid_s1, valid_s2, valid_s3;
	logic                 zero_s1, zero_s2;
	logic signed [PW-1:0] p_xx_s1, p_yy_s1, p_yx_s1, p_xy_s1;
	logic signed [PW:0]   dot_s2, ncr_s2;
	logic [PW:0]          dot_abs, ncr_abs;
	logic                 dot_neg, ncr_neg, dot_is0, ncr_is0;
	tag_t                 tag_d, tag_s3;
	logic [NORM_BITS-1:0] dot_s3, ncr_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// One multiplier per product, then the two sums, then the magnitudes.
	always_ff @(posedge clk) begin
		if (en) begin
			p_xx_s1 <= first_x * second_x;
			p_yy_s1 <= first_y * second_y;
			p_yx_s1 <= first_y * second_x;
			p_xy_s1 <= first_x * second_y;
			zero_s1 <= (first_x == '0 && first_y == '0) ||
				(second_x == '0 && second_y == '0);
			dot_s2  <= (PW+1)'(p_xx_s1) + (PW+1)'(p_yy_s1);
			ncr_s2  <= (PW+1)'(p_yx_s1) - (PW+1)'(p_xy_s1);
			zero_s2 <= zero_s1;
			dot_s3  <= NORM_BITS'(dot_abs[PW-1:0]);
			ncr_s3  <= NORM_BITS'(ncr_abs[PW-1:0]);
			tag_s3  <= tag_d;
		end
	end

	always_comb begin
		dot_neg = dot_s2[PW];
		ncr_neg = ncr_s2[PW];
		dot_abs = dot_neg ? -dot_s2 : dot_s2;
		ncr_abs = ncr_neg ? -ncr_s2 : ncr_s2;
		dot_is0 = (dot_s2 == '0);
		ncr_is0 = (ncr_s2 == '0);
		tag_d.zero = zero_s2;
		tag_d.xneg = dot_neg;
		tag_d.yneg = ncr_neg;
		if (zero_s2) begin
			tag_d.kind = KIND_90;
		end else if (ncr_is0) begin
			tag_d.kind = dot_neg ? KIND_180 : KIND_0;
		end else if (dot_is0) begin
			tag_d.kind = ncr_neg ? KIND_270 : KIND_90;
		end else begin
			tag_d.kind = KIND_CORDIC;
		end
	end

	assign out_valid = valid_s3;
	assign out_tag   = tag_s3;
	assign dot_mag   = dot_s3;
	assign ncr_mag   = ncr_s3;

endmodule

// ===== hdl/vad_norm_cell.sv =====
// One step of the normalising shifter: shifts both magnitudes left by SHIFT if room.
module vad_norm_cell import vad_pkg::*; #(
	parameter int NORM_BITS = 32,
	parameter int SHIFT = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  tag_t                 in_tag,
	input  logic [NORM_BITS-1:0] in_x,
	input  logic [NORM_BITS-1:0] in_y,
	output logic                 out_valid,
	output tag_t                 out_tag,
	output logic [NORM_BITS-1:0] out_x,
	output logic [NORM_BITS-1:0] out_y
);

	logic                 valid_s1;
	tag_t                 tag_s1;
	logic [NORM_BITS-1:0] x_s1, y_s1;
	logic                 room;

	// The shift is taken when the top SHIFT bits of both words are clear.
	assign room = ~|(in_x[NORM_BITS-1 -: SHIFT] | in_y[NORM_BITS-1 -: SHIFT]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1 <= in_tag;
			x_s1   <= room ? (in_x << SHIFT) : in_x;
			y_s1   <= room ? (in_y << SHIFT) : in_y;
		end
	end

	assign out_valid = valid_s1;
	assign out_tag   = tag_s1;
	assign out_x     = x_s1;
	assign out_y     = y_s1;

endmodule

// ===== hdl/vad_cordic_cell.sv =====
// One vectoring rotation of the angle pipeline, for a fixed iteration index.
module vad_cordic_cell import vad_pkg::*; #(
	parameter int STAGE = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  tag_t                 in_tag,
	input  logic signed [CW-1:0] in_x,
	input  logic signed [CW-1:0] in_y,
	input  logic signed [ZW-1:0] in_z,
	output logic                 out_valid,
	output tag_t                 out_tag,
	output logic signed [CW-1:0] out_x,
	output logic signed [CW-1:0] out_y,
	output logic signed [ZW-1:0] out_z
);

	localparam logic signed [ZW-1:0] ATAN = atan_deg(STAGE);

	logic                 valid_s1;
	tag_t                 tag_s1;
	logic signed [CW-1:0] x_s1, y_s1, dx, dy;
	logic signed [ZW-1:0] z_s1;

	// Arithmetic shifts round towards minus infinity.
	assign dx = in_y >>> STAGE;
	assign dy = in_x >>> STAGE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	// Rotate towards the x axis: clockwise while y is not negative.
	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1 <= in_tag;
			if (!in_y[CW-1]) begin
				x_s1 <= in_x + dx;
				y_s1 <= in_y - dy;
				z_s1 <= in_z + ATAN;
			end else begin
				x_s1 <= in_x - dx;
				y_s1 <= in_y + dy;
				z_s1 <= in_z - ATAN;
			end
		end
	end

	assign out_valid = valid_s1;
	assign out_tag   = tag_s1;
	assign out_x     = x_s1;
	assign out_y     = y_s1;
	assign out_z     = z_s1;

endmodule

// ===== hdl/vad_round.sv =====
// Back end: wraps the angle into one turn, rounds it and applies the fixed cases.
module vad_round import vad_pkg::*; #(
	parameter int FRAC_BITS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  tag_t                   in_tag,
	input  logic signed [ZW-1:0]   in_z,
	output logic                   out_valid,
	output logic                   out_zero,
	output logic [FRAC_BITS+8:0]   out_angle
);

	localparam int AW = FRAC_BITS + 9;
	localparam int UW = ZW - 1;
	localparam int SH = ANG_FRAC - FRAC_BITS;
	localparam logic [UW-1:0] HALF = UW'(1) << (SH - 1);
	localparam logic [AW-1:0] ANG90 = AW'(90) << FRAC_BITS;
	localparam logic [AW-1:0] ANG180 = AW'(180) << FRAC_BITS;
	localparam logic [AW-1:0] ANG270 = AW'(270) << FRAC_BITS;
	localparam logic [AW-1:0] ANG360 = AW'(360) << FRAC_BITS;

	logic          valid_s1, valid_s2;
	tag_t          tag_s1;
	logic [ZW-1:0] z_wrap;
	logic [UW-1:0] z_s1, rsum;
	logic [AW-1:0] rnd, ang_d, angle_s2;
	logic          zero_s2;

	// The angle never reaches a full turn, so a negative one needs one add only.
	assign z_wrap = in_z[ZW-1] ? ($unsigned(in_z) + DEG360) : $unsigned(in_z);
	assign rsum   = z_s1 + HALF;
	assign rnd    = rsum[UW-1:SH];

	always_comb begin
		case (tag_s1.kind)
			KIND_0:   ang_d = '0;
			KIND_90:  ang_d = ANG90;
			KIND_180: ang_d = ANG180;
			KIND_270: ang_d = ANG270;
			default:  ang_d = (rnd == ANG360) ? '0 : rnd;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s1     <= z_wrap[UW-1:0];
			tag_s1   <= in_tag;
			angle_s2 <= ang_d;
			zero_s2  <= tag_s1.zero;
		end
	end

	assign out_valid = valid_s2;
	assign out_zero  = zero_s2;
	assign out_angle = angle_s2;

endmodule

// ===== hdl/vad_checker.sv =====
// Port-level checker of the vector angle block and its bind to the top level.
`include "vector_angle_degrees_macros.svh"

module vad_checker #(
	parameter int FRAC_BITS = 8
) (
	input logic                                       clk,
	input logic                                       arst_n,
	input logic                                       s_axis_tvalid,
	input logic                                       s_axis_tready,
	input logic                                       m_axis_tvalid,
	input logic                                       m_axis_tready,
	input logic [((FRAC_BITS + 9 + 7) / 8) * 8 - 1:0] m_axis_tdata,
	input logic [0:0]                                 m_axis_tuser
);

	localparam int AW = FRAC_BITS + 9;
	localparam logic [AW-1:0] ANG90 = AW'(90) << FRAC_BITS;
	localparam logic [AW-1:0] ANG360 = AW'(360) << FRAC_BITS;

	logic [AW-1:0] angle;

	assign angle = m_axis_tdata[AW-1:0];

	// A presented result stays put until it is taken.
	`VAD_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

	// A zero vector always gives exactly 90 degrees.
	`VAD_ASSERT_IMPLY(a_zero_angle, clk, arst_n, m_axis_tvalid && m_axis_tuser[0], angle == ANG90, "zero input without 90 degrees")

	// The angle stays below one full turn.
	`VAD_ASSERT_IMPLY(a_angle_range, clk, arst_n, m_axis_tvalid, angle < ANG360, "angle out of range")

	// Input back-pressure only follows a stall on the output side.
	`VAD_ASSERT_IMPLY(a_ready_drop, clk, arst_n, $fell(s_axis_tready), $past(m_axis_tvalid && !m_axis_tready), "ready dropped without output stall")

endmodule

bind vector_angle_degrees vad_checker #(.FRAC_BITS(FRAC_BITS)) u_vad_checker (.*);
